/* hdl/chs_pkg.sv */
package chs_pkg;

   localparam int KEY_W            = 32;
   localparam int NUM_BUCKETS_DEF  = 6;
   localparam int BUCKET_DEPTH_DEF = 8;
   localparam int DIGIT_W          = 2;
   localparam int DIGITS           = KEY_W / DIGIT_W;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_ERASE  = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic found;
      logic status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic mod_step;
      logic fixup;
      logic fill_rd;
      logic slot_rd;
      logic slot_chk;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic mod_last;
      logic scan_end;
   } ctl_sts_type;

endpackage

/* hdl/chs_datapath.sv */
module chs_datapath #(
   parameter int NUM_BUCKETS  = chs_pkg::NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = chs_pkg::BUCKET_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  chs_pkg::req_type     req_data,
   input  chs_pkg::ctl_cmd_type ctl_cmd,
   output chs_pkg::ctl_sts_type ctl_sts,
   output chs_pkg::rsp_type     rsp_data
);
   import chs_pkg::*;

   localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FW    = $clog2(BUCKET_DEPTH + 1);
   localparam int SW    = $clog2(DIGITS);
   localparam int RW    = BW + DIGIT_W;
   localparam longint WRAP = (longint'(1) << KEY_W) % NUM_BUCKETS;

   localparam logic [RW-1:0] N1     = RW'(NUM_BUCKETS);
   localparam logic [RW-1:0] N2     = RW'(2 * NUM_BUCKETS);
   localparam logic [RW-1:0] N3     = RW'(3 * NUM_BUCKETS);
   localparam logic [BW-1:0] WRAP_R = BW'(WRAP);
   localparam logic [BW:0]   NWRAP  = (BW+1)'(longint'(NUM_BUCKETS) - WRAP);
   localparam logic [FW-1:0] DEPTH  = FW'(BUCKET_DEPTH);

   cmd_type          cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] shift_ff;
   logic [BW-1:0]    rem_ff;
   logic [SW-1:0]    step_ff;
   logic [BW-1:0]    bucket_ff;
   logic [AW-1:0]    base_ff;
   logic [FW-1:0]    fill_ff;
   logic [FW-1:0]    rd_idx_ff;
   logic [FW-1:0]    wr_idx_ff;
   logic             found_ff;
   logic             status_ff;
   logic [KEY_W-1:0] rd_data_ff;
   logic [NUM_BUCKETS-1:0] fill_vld_ff;

   logic [KEY_W-1:0] key_mem  [SLOTS];
   logic [FW-1:0]    fill_mem [NUM_BUCKETS];

   logic [RW-1:0]    acc;
   logic [RW-1:0]    acc_red;
   logic [BW-1:0]    bucket_in;
   logic [AW-1:0]    slot_addr;
   logic             match;
   logic             keep;
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [KEY_W-1:0] mem_wd;
   logic             fill_we;
   logic [FW-1:0]    fill_wd;

   assign acc = {rem_ff, shift_ff[KEY_W-1 -: DIGIT_W]};

   always_comb begin
      priority if (acc >= N3) begin
         acc_red = acc - N3;
      end else if (acc >= N2) begin
         acc_red = acc - N2;
      end else if (acc >= N1) begin
         acc_red = acc - N1;
      end else begin
         acc_red = acc;
      end
   end

   // negative keys: remainder of the raw word corrected by 2^32 mod N
   always_comb begin
      priority if (!key_ff[KEY_W-1]) begin
         bucket_in = rem_ff;
      end else if (rem_ff >= WRAP_R) begin
         bucket_in = rem_ff - WRAP_R;
      end else begin
         bucket_in = BW'({1'b0, rem_ff} + NWRAP);
      end
   end

   assign slot_addr = base_ff + AW'(rd_idx_ff);
   assign match     = (rd_data_ff == key_ff);
   assign keep      = (cmd_ff == CMD_ERASE) && !match;

   always_comb begin
      mem_we  = 1'b0;
      mem_wa  = base_ff + AW'(fill_ff);
      mem_wd  = key_ff;
      fill_we = 1'b0;
      fill_wd = wr_idx_ff;
      if (ctl_cmd.slot_chk && keep) begin
         mem_we = 1'b1;
         mem_wa = base_ff + AW'(wr_idx_ff);
         mem_wd = rd_data_ff;
      end
      if (ctl_cmd.finish) begin
         unique case (cmd_ff)
            CMD_INSERT: begin
               mem_we  = (fill_ff != DEPTH);
               fill_we = (fill_ff != DEPTH);
               fill_wd = fill_ff + FW'(1);
            end
            CMD_ERASE: begin
               fill_we = 1'b1;
            end
            default: begin
               fill_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_wa] <= mem_wd;
      end
      if (ctl_cmd.slot_rd) begin
         rd_data_ff <= key_mem[slot_addr];
      end
      if (fill_we) begin
         fill_mem[bucket_ff] <= fill_wd;
      end
      if (ctl_cmd.fill_rd) begin
         fill_ff <= fill_vld_ff[bucket_ff] ? fill_mem[bucket_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff <= '0;
      end else if (fill_we) begin
         fill_vld_ff[bucket_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.start) begin
         cmd_ff   <= req_data.cmd;
         key_ff   <= req_data.key;
         shift_ff <= req_data.key;
         rem_ff   <= '0;
         step_ff  <= '0;
      end
      if (ctl_cmd.mod_step) begin
         rem_ff   <= acc_red[BW-1:0];
         shift_ff <= shift_ff << DIGIT_W;
         step_ff  <= step_ff + SW'(1);
      end
      if (ctl_cmd.fixup) begin
         bucket_ff <= bucket_in;
      end
      if (ctl_cmd.fill_rd) begin
         base_ff   <= AW'(bucket_ff) * AW'(BUCKET_DEPTH);
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         found_ff  <= 1'b0;
         status_ff <= 1'b0;
      end
      if (ctl_cmd.slot_chk) begin
         rd_idx_ff <= rd_idx_ff + FW'(1);
         if (keep) begin
            wr_idx_ff <= wr_idx_ff + FW'(1);
         end
         if (match) begin
            found_ff <= 1'b1;
         end
      end
      if (ctl_cmd.finish) begin
         status_ff <= (cmd_ff == CMD_INSERT) && (fill_ff == DEPTH);
      end
   end

   assign ctl_sts.mod_last = (step_ff == SW'(DIGITS - 1));
   assign ctl_sts.scan_end = (rd_idx_ff == fill_ff);
   assign rsp_data.found   = found_ff;
   assign rsp_data.status  = status_ff;

endmodule

/* hdl/chs_controller.sv */
module chs_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  chs_pkg::ctl_sts_type ctl_sts,
   output chs_pkg::ctl_cmd_type ctl_cmd
);
   import chs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FIX,
      ST_FILL,
      ST_RD,
      ST_CHK,
      ST_FIN,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      ctl_cmd = '0;
      unique case (state_ff)
         ST_IDLE: ctl_cmd.start    = req_valid;
         ST_MOD:  ctl_cmd.mod_step = 1'b1;
         ST_FIX:  ctl_cmd.fixup    = 1'b1;
         ST_FILL: ctl_cmd.fill_rd  = 1'b1;
         ST_RD:   ctl_cmd.slot_rd  = !ctl_sts.scan_end;
         ST_CHK:  ctl_cmd.slot_chk = 1'b1;
         ST_FIN:  ctl_cmd.finish   = 1'b1;
         ST_RESP: ctl_cmd          = '0;
         default: ctl_cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               if (ctl_sts.mod_last) begin
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX:  state_ff <= ST_FILL;
            ST_FILL: state_ff <= ST_RD;
            ST_RD: begin
               state_ff <= ctl_sts.scan_end ? ST_FIN : ST_CHK;
            end
            ST_CHK:  state_ff <= ST_RD;
            ST_FIN: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (!rsp_stall) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/chained_hash_set_unit.sv */
// Hash set of signed 32-bit keys, one response per request (insert, erase all copies,
// or query). Acceptance is followed by the 2-bit-per-cycle remainder unit that picks
// the bucket, then a read and a compare for each slot already stored in that bucket,
// on the single key memory. Requests are taken one at a time; req_stall stays high
// from acceptance until the response has been taken. No clearing pass after reset.
module chained_hash_set_unit #(
   parameter int NUM_BUCKETS  = chs_pkg::NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = chs_pkg::BUCKET_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chs_pkg::rsp_type rsp_data
);
   import chs_pkg::*;

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   chs_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl_sts   (ctl_sts),
      .ctl_cmd   (ctl_cmd)
   );

   chs_datapath #(
      .NUM_BUCKETS  (NUM_BUCKETS),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl_cmd  (ctl_cmd),
      .ctl_sts  (ctl_sts),
      .rsp_data (rsp_data)
   );

endmodule

/* hdl/chs_checker.sv */
module chs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input chs_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response is pending");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response in the cycle after a request");

   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("response repeated");

endmodule

bind chained_hash_set_unit chs_checker u_chs_checker (.*);

/* sim/chained_hash_set_unit_tb.sv */
`timescale 1ns / 1ps

module chained_hash_set_unit_tb;
   import chs_pkg::*;

   localparam int         NB          = NUM_BUCKETS_DEF;
   localparam int         DEPTH       = BUCKET_DEPTH_DEF;
   localparam logic [1:0] CMD_SPARE   = 2'd3;
   localparam int         RSP_LATENCY = 21 + 2 * DEPTH;
   localparam int         BLOCKS      = 9;
   localparam int         BLOCK_LEN   = 150;
   localparam int         POOL        = 24;

   class hash_set_scoreboard;
      logic [KEY_W-1:0] slots [NB][DEPTH];
      int unsigned      fill [NB];
      rsp_type          expected_rsp [$];
      int unsigned      errors;
      int unsigned      n_insert;
      int unsigned      n_erase;
      int unsigned      n_query;
      int unsigned      n_drop;
      int unsigned      n_hit;
      int unsigned      n_checked;

      function int unsigned home_bucket(logic [KEY_W-1:0] key);
         longint k;
         longint r;
         k = longint'($signed(key));
         r = k % NB;
         if (r < 0) r += NB;
         return r[31:0];
      endfunction

      function void note_request(req_type req);
         int unsigned b;
         int unsigned w;
         rsp_type     rsp;
         b   = home_bucket(req.key);
         rsp = '0;
         for (int i = 0; i < fill[b]; i++)
            if (slots[b][i] == req.key) rsp.found = 1'b1;
         case (req.cmd)
            CMD_INSERT: begin
               n_insert++;
               if (fill[b] >= DEPTH) begin
                  rsp.status = 1'b1;
                  n_drop++;
               end else begin
                  slots[b][fill[b]] = req.key;
                  fill[b]++;
               end
            end
            CMD_ERASE: begin
               n_erase++;
               w = 0;
               for (int i = 0; i < fill[b]; i++) begin
                  if (slots[b][i] != req.key) begin
                     slots[b][w] = slots[b][i];
                     w++;
                  end
               end
               fill[b] = w;
            end
            default: n_query++;
         endcase
         if (rsp.found) n_hit++;
         expected_rsp = {expected_rsp, rsp};
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response: found=%0b status=%0b", got.found, got.status);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         n_checked++;
         if (got.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit                 quiet;
   hash_set_scoreboard sb = new();

   chained_hash_set_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // gap is counted from the point the block can take a new request
   task automatic send_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
      int unsigned gap;
      req_type     req;
      req.cmd = cmd_type'(cmd);
      req.key = key;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         repeat (gap - 1) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(req);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_rsp.size() != 0) @(posedge clock);
   endtask

   // stall is held for the drawn count once a response is actually on offer
   initial begin
      int unsigned hold;
      wait (reset == 1'b0);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 14);
         rsp_stall <= (hold != 0);
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if (hold != 0) begin
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
         sb.check_response(rsp_data);
      end
   end

   initial begin
      logic [KEY_W-1:0] pool [POOL];
      logic [KEY_W-1:0] key;
      logic [1:0]       cmd;
      int unsigned      ins_pct;
      int unsigned      er_pct;
      int unsigned      pick;
      int               hot;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      quiet = 1'b0;

      send_request(CMD_QUERY,  32'd0);
      send_request(CMD_INSERT, 32'h7FFF_FFFF);
      send_request(CMD_INSERT, 32'h8000_0000);
      send_request(CMD_INSERT, 32'hFFFF_FFFF);
      send_request(CMD_INSERT, 32'd0);
      send_request(CMD_INSERT, 32'd0);
      send_request(CMD_QUERY,  32'h8000_0000);
      send_request(CMD_INSERT, 32'd6);
      send_request(CMD_INSERT, 32'd12);
      send_request(CMD_INSERT, -32'sd6);
      send_request(CMD_INSERT, -32'sd12);
      send_request(CMD_INSERT, 32'd18);
      send_request(CMD_INSERT, 32'd24);
      // bucket zero is full now
      send_request(CMD_INSERT, 32'd30);
      send_request(CMD_INSERT, 32'd6);
      send_request(CMD_ERASE,  32'd0);
      send_request(CMD_ERASE,  32'd0);
      send_request(CMD_QUERY,  32'd6);
      send_request(CMD_SPARE,  32'd6);
      send_request(CMD_SPARE,  32'd0);
      send_request(CMD_ERASE,  32'h7FFF_FFFF);
      send_request(CMD_QUERY,  32'h7FFF_FFFF);
      send_request(CMD_INSERT, 32'd30);
      drain();

      for (int blk = 0; blk < BLOCKS; blk++) begin
         quiet   = (blk % 4 == 2);
         ins_pct = (blk % 2 == 0) ? 60 : 30;
         er_pct  = (blk % 2 == 0) ? 10 : 30;
         hot     = blk % NB;
         for (int i = 0; i < POOL; i++) begin
            case (i % 3)
               0:       pool[i] = $urandom();
               1:       pool[i] = int'($urandom_range(0, 60)) - 30;
               default: pool[i] = (int'($urandom_range(0, 2000)) - 1000) * NB + hot;
            endcase
         end
         for (int n = 0; n < BLOCK_LEN; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < ins_pct)               cmd = CMD_INSERT;
            else if (pick < ins_pct + er_pct) cmd = CMD_ERASE;
            else if (pick < 95)               cmd = CMD_QUERY;
            else                              cmd = CMD_SPARE;
            key = ($urandom_range(0, 19) == 0) ? $urandom() : pool[$urandom_range(0, POOL - 1)];
            send_request(cmd, key);
         end
         drain();
      end

      repeat (RSP_LATENCY + 3) @(posedge clock);
      $display("Ran %0d requests: %0d inserts, %0d erases, %0d lookups; %0d responses checked.",
               sb.n_insert + sb.n_erase + sb.n_query, sb.n_insert, sb.n_erase, sb.n_query,
               sb.n_checked);
      $display("Saw %0d hits and %0d inserts dropped on a full bucket.", sb.n_hit, sb.n_drop);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/chs_pkg.sv
hdl/chs_datapath.sv
hdl/chs_controller.sv
hdl/chained_hash_set_unit.sv
hdl/chs_checker.sv
sim/chained_hash_set_unit_tb.sv
